@@ rtl/rc2_block_cipher_assert.svh @@
// assertion macros used by the rc2 core
`ifndef RC2_BLOCK_CIPHER_ASSERT_SVH
`define RC2_BLOCK_CIPHER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RC2_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rc2 check failed");

// next-cycle implication, checked out of reset
`define RC2_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rc2 check failed");

`endif

@@ rtl/rc2_pkg.sv @@
package rc2_pkg;

   // operation codes
   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_ENC  = 2'd1;
   localparam logic [1:0] OP_DEC  = 2'd2;
   localparam logic [1:0] OP_NOP  = 2'd3;

   // register indexes
   localparam logic REG_KEY_LENGTH = 1'b0;
   localparam logic REG_EFF_BITS   = 1'b1;

   localparam int          STORE_BYTES  = 128;
   localparam logic [10:0] MAX_EFF_BITS = 11'd1024;
   localparam logic [7:0]  KEY_LEN_RST  = 8'd16;

   // word passed from the front queue to the core
   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  key_byte;
      logic [63:0] data;
   } cmd_type;

   // fixed permutation of the key schedule
   localparam logic [7:0] PI_TABLE [0:255] = '{
      8'd217,8'd120,8'd249,8'd196,8'd25,8'd221,8'd181,8'd237,
      8'd40,8'd233,8'd253,8'd121,8'd74,8'd160,8'd216,8'd157,
      8'd198,8'd126,8'd55,8'd131,8'd43,8'd118,8'd83,8'd142,
      8'd98,8'd76,8'd100,8'd136,8'd68,8'd139,8'd251,8'd162,
      8'd23,8'd154,8'd89,8'd245,8'd135,8'd179,8'd79,8'd19,
      8'd97,8'd69,8'd109,8'd141,8'd9,8'd129,8'd125,8'd50,
      8'd189,8'd143,8'd64,8'd235,8'd134,8'd183,8'd123,8'd11,
      8'd240,8'd149,8'd33,8'd34,8'd92,8'd107,8'd78,8'd130,
      8'd84,8'd214,8'd101,8'd147,8'd206,8'd96,8'd178,8'd28,
      8'd115,8'd86,8'd192,8'd20,8'd167,8'd140,8'd241,8'd220,
      8'd18,8'd117,8'd202,8'd31,8'd59,8'd190,8'd228,8'd209,
      8'd66,8'd61,8'd212,8'd48,8'd163,8'd60,8'd182,8'd38,
      8'd111,8'd191,8'd14,8'd218,8'd70,8'd105,8'd7,8'd87,
      8'd39,8'd242,8'd29,8'd155,8'd188,8'd148,8'd67,8'd3,
      8'd248,8'd17,8'd199,8'd246,8'd144,8'd239,8'd62,8'd231,
      8'd6,8'd195,8'd213,8'd47,8'd200,8'd102,8'd30,8'd215,
      8'd8,8'd232,8'd234,8'd222,8'd128,8'd82,8'd238,8'd247,
      8'd132,8'd170,8'd114,8'd172,8'd53,8'd77,8'd106,8'd42,
      8'd150,8'd26,8'd210,8'd113,8'd90,8'd21,8'd73,8'd116,
      8'd75,8'd159,8'd208,8'd94,8'd4,8'd24,8'd164,8'd236,
      8'd194,8'd224,8'd65,8'd110,8'd15,8'd81,8'd203,8'd204,
      8'd36,8'd145,8'd175,8'd80,8'd161,8'd244,8'd112,8'd57,
      8'd153,8'd124,8'd58,8'd133,8'd35,8'd184,8'd180,8'd122,
      8'd252,8'd2,8'd54,8'd91,8'd37,8'd85,8'd151,8'd49,
      8'd45,8'd93,8'd250,8'd152,8'd227,8'd138,8'd146,8'd174,
      8'd5,8'd223,8'd41,8'd16,8'd103,8'd108,8'd186,8'd201,
      8'd211,8'd0,8'd230,8'd207,8'd225,8'd158,8'd168,8'd44,
      8'd99,8'd22,8'd1,8'd63,8'd88,8'd226,8'd137,8'd169,
      8'd13,8'd56,8'd52,8'd27,8'd171,8'd51,8'd255,8'd176,
      8'd187,8'd72,8'd12,8'd95,8'd185,8'd177,8'd205,8'd46,
      8'd197,8'd243,8'd219,8'd71,8'd229,8'd165,8'd156,8'd119,
      8'd10,8'd166,8'd32,8'd104,8'd254,8'd127,8'd193,8'd173
   };

endpackage

@@ rtl/rc2_ram.sv @@
module rc2_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_a_ff;
   logic [WIDTH-1:0] rdata_b_ff;

   // one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_a_ff <= mem_ff[raddr_a];
      rdata_b_ff <= mem_ff[raddr_b];
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

@@ rtl/rc2_front.sv @@
module rc2_front import rc2_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_key_byte,
   input  logic [63:0] req_data_in,
   output logic        cmd_valid,
   input  logic        cmd_ready,
   output cmd_type     cmd
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type         slot_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            accept;
   logic            enq;
   logic            deq;

   // accept words while not full, queue only the ones the core acts on
   assign req_full  = (cnt_ff == CW'(DEPTH));
   assign accept    = req_push && !req_full;
   assign enq       = accept && (req_operation != OP_NOP);
   assign cmd_valid = (cnt_ff != '0);
   assign deq       = cmd_valid && cmd_ready;
   assign cmd       = slot_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (enq) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (deq) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (enq && !deq) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (deq && !enq) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (enq) begin
         slot_ff[wr_ptr_ff] <= '{op: req_operation, key_byte: req_key_byte,
                                 data: req_data_in};
      end
   end

endmodule

@@ rtl/rc2_core.sv @@
`include "rc2_block_cipher_assert.svh"
module rc2_core import rc2_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [10:0] csr_wdata,
   input  logic        cmd_valid,
   output logic        cmd_ready,
   input  cmd_type     cmd,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [63:0] rsp_data_out
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EXP1  = 3'd1;
   localparam logic [2:0] ST_EXP2F = 3'd2;
   localparam logic [2:0] ST_EXP2  = 3'd3;
   localparam logic [2:0] ST_CIPH  = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic              phase_ff, phase_in;
   logic [7:0]        key_len_ff;
   logic [10:0]       eff_bits_ff;
   logic [7:0]        count_ff, count_in;
   logic [7:0]        idx_ff, idx_in;
   logic [7:0]        t_ff, t_in;
   logic [7:0]        t8_ff, t8_in;
   logic [7:0]        tm_ff, tm_in;
   logic              dec_ff, dec_in;
   logic [3:0]        j_ff, j_in;
   logic [1:0]        i_ff, i_in;
   logic              mash_ff, mash_in;
   logic [3:0][15:0]  r_ff, r_in;
   logic              out_valid_ff, out_valid_in;
   logic [63:0]       out_data_ff;
   logic              lsb_a_ff, lsb_b_ff;

   logic [7:0]        t_use;
   logic [10:0]       t1;
   logic [11:0]       t1_round;
   logic [2:0]        tm_shift;
   logic [8:0]        next_count;
   logic              slot_free;

   logic              ram_we;
   logic [6:0]        ram_waddr;
   logic [7:0]        ram_wdata;
   logic [6:0]        ra, rb;
   logic [7:0]        even_a, even_b, odd_a, odd_b;
   logic [7:0]        byte_a, byte_b;
   logic [7:0]        sum_ab;
   logic [15:0]       kw;
   logic [15:0]       ca, cb, cc, cx;
   logic [15:0]       fmix;
   logic [15:0]       vsum, vrot, xror, vdif;
   logic [15:0]       r_new;
   logic              seq_done;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_len_ff  <= KEY_LEN_RST;
         eff_bits_ff <= '0;
      end else if (csr_write) begin
         if (csr_index == REG_KEY_LENGTH) begin
            key_len_ff <= csr_wdata[7:0];
         end else begin
            eff_bits_ff <= csr_wdata;
         end
      end
   end

   // key length in use and derived expansion constants
   always_comb begin
      if (key_len_ff == 8'd0) begin
         t_use = 8'd1;
      end else if (key_len_ff > 8'(STORE_BYTES)) begin
         t_use = 8'(STORE_BYTES);
      end else begin
         t_use = key_len_ff;
      end
      if (eff_bits_ff == '0 || eff_bits_ff > MAX_EFF_BITS) begin
         t1 = {t_use, 3'b000};
      end else begin
         t1 = eff_bits_ff;
      end
      t1_round   = {1'b0, t1} + 12'd7;
      tm_shift   = 3'(3'd0 - t1[2:0]);
      next_count = {1'b0, count_ff} + 9'd1;
   end

   // key store in even and odd byte banks
   rc2_ram #(.WIDTH(8), .DEPTH(STORE_BYTES / 2)) u_even (
      .clock   (clock),
      .we      (ram_we && !ram_waddr[0]),
      .waddr   (ram_waddr[6:1]),
      .wdata   (ram_wdata),
      .raddr_a (ra[6:1]),
      .raddr_b (rb[6:1]),
      .rdata_a (even_a),
      .rdata_b (even_b)
   );

   rc2_ram #(.WIDTH(8), .DEPTH(STORE_BYTES / 2)) u_odd (
      .clock   (clock),
      .we      (ram_we && ram_waddr[0]),
      .waddr   (ram_waddr[6:1]),
      .wdata   (ram_wdata),
      .raddr_a (ra[6:1]),
      .raddr_b (rb[6:1]),
      .rdata_a (odd_a),
      .rdata_b (odd_b)
   );

   always_ff @(posedge clock) begin
      lsb_a_ff <= ra[0];
      lsb_b_ff <= rb[0];
   end

   assign byte_a = lsb_a_ff ? odd_a : even_a;
   assign byte_b = lsb_b_ff ? odd_b : even_b;
   assign sum_ab = byte_a + byte_b;
   assign kw     = {odd_a, even_a};

   // read addresses per state
   always_comb begin
      ra = '0;
      rb = '0;
      unique case (state_ff)
         ST_EXP1: begin
            ra = 7'(idx_ff - 8'd1);
            rb = 7'(idx_ff - t_ff);
         end
         ST_EXP2F: begin
            ra = idx_ff[6:0];
         end
         ST_EXP2: begin
            ra = 7'(idx_ff + 8'd1);
            rb = 7'(idx_ff + t8_ff);
         end
         ST_CIPH: begin
            ra = mash_ff ? {r_ff[2'(i_ff + 2'd3)][5:0], 1'b0} : {j_ff, i_ff, 1'b0};
         end
         default: begin
            ra = '0;
         end
      endcase
   end

   // one mixing or mashing step on word i
   always_comb begin
      ca   = r_ff[2'(i_ff + 2'd3)];
      cb   = r_ff[2'(i_ff + 2'd2)];
      cc   = r_ff[2'(i_ff + 2'd1)];
      cx   = r_ff[i_ff];
      fmix = (ca & cb) | (~ca & cc);
      vsum = cx + kw + fmix;
      case (i_ff)
         2'd0:    vrot = {vsum[14:0], vsum[15]};
         2'd1:    vrot = {vsum[13:0], vsum[15:14]};
         2'd2:    vrot = {vsum[12:0], vsum[15:13]};
         default: vrot = {vsum[10:0], vsum[15:11]};
      endcase
      case (i_ff)
         2'd0:    xror = {cx[0], cx[15:1]};
         2'd1:    xror = {cx[1:0], cx[15:2]};
         2'd2:    xror = {cx[2:0], cx[15:3]};
         default: xror = {cx[4:0], cx[15:5]};
      endcase
      vdif = xror - kw - fmix;
      if (mash_ff) begin
         r_new = dec_ff ? (cx - kw) : (cx + kw);
      end else begin
         r_new = dec_ff ? vdif : vrot;
      end
   end

   assign slot_free = !out_valid_ff || rsp_pop;
   assign cmd_ready = (state_ff == ST_IDLE);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      t_in         = t_ff;
      t8_in        = t8_ff;
      tm_in        = tm_ff;
      dec_in       = dec_ff;
      j_in         = j_ff;
      i_in         = i_ff;
      mash_in      = mash_ff;
      r_in         = r_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      ram_we       = 1'b0;
      ram_waddr    = idx_ff[6:0];
      ram_wdata    = PI_TABLE[sum_ab];
      seq_done     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               phase_in = 1'b0;
               if (cmd.op == OP_LOAD) begin
                  // store the key byte, expand once the key is complete
                  ram_we    = 1'b1;
                  ram_waddr = count_ff[6:0];
                  ram_wdata = cmd.key_byte;
                  if (next_count >= {1'b0, t_use}) begin
                     count_in = '0;
                     t_in     = t_use;
                     t8_in    = t1_round[10:3];
                     tm_in    = 8'hFF >> tm_shift;
                     if (t_use == 8'(STORE_BYTES)) begin
                        state_in = ST_EXP2F;
                        idx_in   = 8'(STORE_BYTES) - t1_round[10:3];
                     end else begin
                        state_in = ST_EXP1;
                        idx_in   = t_use;
                     end
                  end else begin
                     count_in = next_count[7:0];
                  end
               end else begin
                  state_in = ST_CIPH;
                  dec_in   = (cmd.op == OP_DEC);
                  j_in     = (cmd.op == OP_DEC) ? 4'd15 : 4'd0;
                  i_in     = (cmd.op == OP_DEC) ? 2'd3 : 2'd0;
                  mash_in  = 1'b0;
                  r_in     = cmd.data;
               end
            end
         end
         ST_EXP1: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               ram_we    = 1'b1;
               ram_wdata = PI_TABLE[sum_ab];
               if (idx_ff == 8'(STORE_BYTES - 1)) begin
                  state_in = ST_EXP2F;
                  idx_in   = 8'(STORE_BYTES) - t8_ff;
               end else begin
                  idx_in = idx_ff + 8'd1;
               end
            end
         end
         ST_EXP2F: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               ram_we    = 1'b1;
               ram_wdata = PI_TABLE[byte_a & tm_ff];
               if (idx_ff == 8'd0) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_EXP2;
                  idx_in   = idx_ff - 8'd1;
               end
            end
         end
         ST_EXP2: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               ram_we    = 1'b1;
               ram_wdata = PI_TABLE[byte_a ^ byte_b];
               if (idx_ff == 8'd0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff - 8'd1;
               end
            end
         end
         ST_CIPH: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               r_in[i_ff] = r_new;
               if (!dec_ff) begin
                  if (i_ff != 2'd3) begin
                     i_in = i_ff + 2'd1;
                  end else if (!mash_ff && (j_ff == 4'd4 || j_ff == 4'd10)) begin
                     mash_in = 1'b1;
                     i_in    = 2'd0;
                  end else begin
                     mash_in  = 1'b0;
                     i_in     = 2'd0;
                     seq_done = (j_ff == 4'd15);
                     j_in     = j_ff + 4'd1;
                  end
               end else begin
                  if (i_ff != 2'd0) begin
                     i_in = i_ff - 2'd1;
                  end else if (!mash_ff && (j_ff == 4'd11 || j_ff == 4'd5)) begin
                     mash_in = 1'b1;
                     i_in    = 2'd3;
                  end else begin
                     mash_in  = 1'b0;
                     i_in     = 2'd3;
                     seq_done = (j_ff == 4'd0);
                     j_in     = j_ff - 4'd1;
                  end
               end
               if (seq_done) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= 1'b0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      t_ff    <= t_in;
      t8_ff   <= t8_in;
      tm_ff   <= tm_in;
      dec_ff  <= dec_in;
      j_ff    <= j_in;
      i_ff    <= i_in;
      mash_ff <= mash_in;
      r_ff    <= r_in;
      if (state_ff == ST_DONE && slot_free) begin
         out_data_ff <= r_ff;
      end
   end

   assign rsp_empty    = !out_valid_ff;
   assign rsp_data_out = out_data_ff;

   // checks
   `RC2_ASSERT_NOW(a_exp1_index, state_ff == ST_EXP1, idx_ff >= t_ff)
   `RC2_ASSERT_NOW(a_cipher_no_write, state_ff == ST_CIPH, !ram_we)
   `RC2_ASSERT_NOW(a_count_bound, 1'b1, count_ff < 8'(STORE_BYTES))
   `RC2_ASSERT_NEXT(a_done_delivers, state_ff == ST_DONE && slot_free, out_valid_ff)

endmodule

@@ rtl/rc2_block_cipher.sv @@
// blocks: one at a time through the shared round unit (72 steps, each waiting on a registered
//   read of a key word from the key store); no new word is taken until the result is delivered
// key byte load: the last byte of a key starts an expansion of the key store, and no word is
//   taken until the expansion ends
// reset: synchronous, active high; clears control state, key length 16, effective bits 0
module rc2_block_cipher import rc2_pkg::*; #(
   parameter int CMD_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_key_byte,
   input  logic [63:0] req_data_in,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [63:0] rsp_data_out,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [10:0] csr_wdata
);

   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd;

   // front: accepts and queues words
   rc2_front #(.DEPTH(CMD_DEPTH)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_operation (req_operation),
      .req_key_byte  (req_key_byte),
      .req_data_in   (req_data_in),
      .cmd_valid     (cmd_valid),
      .cmd_ready     (cmd_ready),
      .cmd           (cmd)
   );

   // back: key store, expansion and rounds
   rc2_core u_core (
      .clock        (clock),
      .reset        (reset),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd_valid    (cmd_valid),
      .cmd_ready    (cmd_ready),
      .cmd          (cmd),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_data_out (rsp_data_out)
   );

endmodule
